/* hdl/gff_pkg.sv */
package gff_pkg;

    localparam int CRD_W = 8;
    localparam int CNT_W = 13;
    localparam logic [7:0] SPACE_CHAR = 8'd32;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_RECT  = 2'd1,
        OP_FLOOD = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_COLS  = 2'd0,
        REG_ROWS  = 2'd1,
        REG_PAINT = 2'd2,
        REG_ERASE = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        DIR_LEFT,
        DIR_RIGHT,
        DIR_UP,
        DIR_DOWN,
        DIR_HOLD
    } dir_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_WRITE,
        S_RECT,
        S_RDISS,
        S_RDCAP,
        S_FCLR,
        S_FSEED,
        S_FTGT,
        S_FPOP,
        S_FLOAD,
        S_FPAINT,
        S_NBISS,
        S_NBCHK,
        S_RESP
    } state_t;

    typedef struct packed {
        op_t        opcode;
        logic [5:0] col_a;
        logic [5:0] row_a;
        logic [5:0] col_b;
        logic [5:0] row_b;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       cell_value;
        logic [CNT_W-1:0] cells_changed;
        logic             status;
    } out_item_t;

endpackage

/* hdl/gff_ram.sv */
module gff_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/gff_step.sv */
module gff_step import gff_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int AW       = 12
)
(
    input  logic [CRD_W-1:0] c,
    input  logic [CRD_W-1:0] r,
    input  dir_t             dir,
    input  logic [CRD_W:0]   ucols,
    input  logic [CRD_W:0]   urows,
    output logic [CRD_W-1:0] nc,
    output logic [CRD_W-1:0] nr,
    output logic             ok,
    output logic [AW-1:0]    idx
);

    localparam logic [AW-1:0] ROWS_K = AW'(MAX_ROWS);

    logic [CRD_W:0] c_w;
    logic [CRD_W:0] r_w;
    logic [CRD_W:0] nc_w;
    logic [CRD_W:0] nr_w;

    assign c_w = {1'b0, c};
    assign r_w = {1'b0, r};

    always_comb
    begin
        nc_w = c_w;
        nr_w = r_w;
        ok   = 1'b0;
        case (dir)
            DIR_LEFT:
            begin
                nc_w = c_w - 1'b1;
                ok   = (c != '0);
            end
            DIR_RIGHT:
            begin
                nc_w = c_w + 1'b1;
                ok   = (nc_w < ucols);
            end
            DIR_UP:
            begin
                nr_w = r_w - 1'b1;
                ok   = (r != '0);
            end
            DIR_DOWN:
            begin
                nr_w = r_w + 1'b1;
                ok   = (nr_w < urows);
            end
            DIR_HOLD:
            begin
                ok = 1'b1;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    assign nc  = nc_w[CRD_W-1:0];
    assign nr  = nr_w[CRD_W-1:0];
    assign idx = AW'(nc) * ROWS_K + AW'(nr);

endmodule

/* hdl/grid_flood_fill_engine_top.sv */
// channel | signals                         | transfer when
// in      | in_valid, in_ready, in_data     | in_valid & in_ready
// out     | out_valid, out_ready, out_data  | out_valid & out_ready
// cfg     | cfg_we, cfg_index, cfg_wdata    | cfg_we
// Flood fill first clears the visited map over all MAX_COLS*MAX_ROWS cells, then
// pops, paints and checks the neighbors of each cell; one sequencer drives the RAMs
// (one write and one read port each) and shares a single step unit.
// Reset: grid clearing pass over all MAX_COLS*MAX_ROWS cells, in_ready low.
// One item at a time; out register lets the next transfer in while a result waits.
module grid_flood_fill_engine_top import gff_pkg::*;
#(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data,
    input  logic       cfg_we,
    input  reg_idx_t   cfg_index,
    input  logic [7:0] cfg_wdata
);

    localparam int CELLS = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW1   = CRD_W + 1;
    localparam int SW    = 2 * CRD_W;
    localparam logic [CRD_W:0] COLS_LIM  = CW1'(MAX_COLS);
    localparam logic [CRD_W:0] ROWS_LIM  = CW1'(MAX_ROWS);
    localparam logic [AW-1:0]  LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW:0]    SP_FULL   = (AW + 1)'(CELLS);

    state_t state_reg, state_next;

    logic [6:0] cols_reg, rows_reg;
    logic [7:0] paint_reg;
    logic       erase_reg;

    logic [AW-1:0]    sweep_reg;
    logic [AW:0]      sp_reg;
    logic [CRD_W-1:0] ca_reg, ra_reg, cb_reg, rb_reg, cur_c_reg, cur_r_reg;
    dir_t             dir_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [7:0]       target_reg, value_reg;
    logic             bad_reg;
    out_item_t        out_reg;
    logic             out_valid_reg;

    logic [CRD_W:0] ucols, urows;
    logic [7:0]     pv;
    logic           in_ok;
    logic           accept;

    logic [CRD_W-1:0] u_c, u_r, u_nc, u_nr;
    dir_t             u_dir;
    logic             u_ok;
    logic [AW-1:0]    u_idx;

    logic          g_we, v_we, v_wdata, v_rdata, s_we;
    logic [AW-1:0] g_waddr, g_raddr, v_waddr, v_raddr, s_waddr, s_raddr;
    logic [7:0]    g_wdata, g_rdata;
    logic [SW-1:0] s_wdata, s_rdata;

    logic push_ok;
    logic last_dir;
    logic out_free;

    assign ucols = (CW1'(cols_reg) > COLS_LIM) ? COLS_LIM : CW1'(cols_reg);
    assign urows = (CW1'(rows_reg) > ROWS_LIM) ? ROWS_LIM : CW1'(rows_reg);
    assign pv    = erase_reg ? SPACE_CHAR : paint_reg;

    assign in_ok = (CW1'(in_data.col_a) < ucols) && (CW1'(in_data.row_a) < urows)
                && ((in_data.opcode != OP_RECT)
                    || ((CW1'(in_data.col_b) < ucols) && (CW1'(in_data.row_b) < urows)));

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign push_ok  = !v_rdata && (g_rdata == target_reg) && (sp_reg != SP_FULL);
    assign last_dir = (dir_reg == DIR_DOWN);

    gff_step #(.MAX_ROWS(MAX_ROWS), .AW(AW)) u_step
    (
        .c     (u_c),
        .r     (u_r),
        .dir   (u_dir),
        .ucols (ucols),
        .urows (urows),
        .nc    (u_nc),
        .nr    (u_nr),
        .ok    (u_ok),
        .idx   (u_idx)
    );

    gff_ram #(.WIDTH(8), .DEPTH(CELLS)) u_grid
    (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    gff_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited
    (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    gff_ram #(.WIDTH(SW), .DEPTH(CELLS)) u_stack
    (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (sweep_reg == LAST_CELL)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!in_ok)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        case (in_data.opcode)
                            OP_WRITE: state_next = S_WRITE;
                            OP_RECT:  state_next = S_RECT;
                            OP_FLOOD: state_next = S_FCLR;
                            OP_READ:  state_next = S_RDISS;
                            default:  state_next = S_RESP;
                        endcase
                    end
                end
            end
            S_WRITE: state_next = S_RESP;
            S_RECT:
            begin
                if ((cur_r_reg == rb_reg) && (cur_c_reg == cb_reg))
                begin
                    state_next = S_RESP;
                end
            end
            S_RDISS: state_next = S_RDCAP;
            S_RDCAP: state_next = S_RESP;
            S_FCLR:
            begin
                if (sweep_reg == LAST_CELL)
                begin
                    state_next = S_FSEED;
                end
            end
            S_FSEED:  state_next = S_FTGT;
            S_FTGT:   state_next = S_FPOP;
            S_FPOP:   state_next = S_FLOAD;
            S_FLOAD:  state_next = S_FPAINT;
            S_FPAINT: state_next = S_NBISS;
            S_NBISS, S_NBCHK:
            begin
                if ((state_reg == S_NBISS) && u_ok)
                begin
                    state_next = S_NBCHK;
                end
                else if (!last_dir)
                begin
                    state_next = S_NBISS;
                end
                else if ((state_reg == S_NBCHK) && push_ok)
                begin
                    state_next = S_FPOP;
                end
                else if (sp_reg == '0)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_FPOP;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
    end

    always_comb
    begin
        u_c     = cur_c_reg;
        u_r     = cur_r_reg;
        u_dir   = DIR_HOLD;
        g_we    = 1'b0;
        g_waddr = u_idx;
        g_wdata = pv;
        g_raddr = u_idx;
        v_we    = 1'b0;
        v_waddr = u_idx;
        v_wdata = 1'b1;
        v_raddr = u_idx;
        s_we    = 1'b0;
        s_waddr = sp_reg[AW-1:0];
        s_wdata = {u_nc, u_nr};
        s_raddr = sp_reg[AW-1:0] - 1'b1;
        case (state_reg)
            S_INIT:
            begin
                g_we    = 1'b1;
                g_waddr = sweep_reg;
                g_wdata = SPACE_CHAR;
            end
            S_WRITE:
            begin
                u_c  = ca_reg;
                u_r  = ra_reg;
                g_we = 1'b1;
            end
            S_RECT, S_FPAINT:
            begin
                g_we = 1'b1;
            end
            S_RDISS, S_FSEED:
            begin
                u_c = ca_reg;
                u_r = ra_reg;
            end
            S_FCLR:
            begin
                v_we    = 1'b1;
                v_waddr = sweep_reg;
                v_wdata = 1'b0;
            end
            S_FTGT:
            begin
                u_c  = ca_reg;
                u_r  = ra_reg;
                v_we = 1'b1;
                s_we = 1'b1;
            end
            S_NBISS:
            begin
                u_dir = dir_reg;
            end
            S_NBCHK:
            begin
                u_dir = dir_reg;
                v_we  = push_ok;
                s_we  = push_ok;
            end
            default:
            begin
                u_dir = DIR_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg  <= 7'd64;
            rows_reg  <= 7'd64;
            paint_reg <= SPACE_CHAR;
            erase_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COLS:  cols_reg  <= cfg_wdata[6:0];
                REG_ROWS:  rows_reg  <= cfg_wdata[6:0];
                REG_PAINT: paint_reg <= cfg_wdata;
                REG_ERASE: erase_reg <= cfg_wdata[0];
                default:   erase_reg <= erase_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            sweep_reg     <= '0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_INIT) || (state_reg == S_FCLR))
            begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            else
            begin
                sweep_reg <= '0;
            end
            if (state_reg == S_FTGT)
            begin
                sp_reg <= (AW + 1)'(1);
            end
            else if (state_reg == S_FPOP)
            begin
                sp_reg <= sp_reg - 1'b1;
            end
            else if ((state_reg == S_NBCHK) && push_ok)
            begin
                sp_reg <= sp_reg + 1'b1;
            end
            if ((state_reg == S_RESP) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cnt_reg   <= '0;
                value_reg <= '0;
                bad_reg   <= !in_ok;
                if ((in_data.opcode == OP_RECT) && (in_data.col_b < in_data.col_a))
                begin
                    ca_reg <= CRD_W'(in_data.col_b);
                    cb_reg <= CRD_W'(in_data.col_a);
                end
                else
                begin
                    ca_reg <= CRD_W'(in_data.col_a);
                    cb_reg <= CRD_W'(in_data.col_b);
                end
                if ((in_data.opcode == OP_RECT) && (in_data.row_b < in_data.row_a))
                begin
                    ra_reg <= CRD_W'(in_data.row_b);
                    rb_reg <= CRD_W'(in_data.row_a);
                end
                else
                begin
                    ra_reg <= CRD_W'(in_data.row_a);
                    rb_reg <= CRD_W'(in_data.row_b);
                end
                cur_c_reg <= (in_data.col_b < in_data.col_a) ? CRD_W'(in_data.col_b)
                                                             : CRD_W'(in_data.col_a);
                cur_r_reg <= (in_data.row_b < in_data.row_a) ? CRD_W'(in_data.row_b)
                                                             : CRD_W'(in_data.row_a);
            end
            S_WRITE:
            begin
                cnt_reg <= CNT_W'(1);
            end
            S_RECT:
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cur_r_reg == rb_reg)
                begin
                    cur_r_reg <= ra_reg;
                    cur_c_reg <= cur_c_reg + 1'b1;
                end
                else
                begin
                    cur_r_reg <= cur_r_reg + 1'b1;
                end
            end
            S_RDCAP:
            begin
                value_reg <= g_rdata;
            end
            S_FTGT:
            begin
                target_reg <= g_rdata;
            end
            S_FLOAD:
            begin
                cur_c_reg <= s_rdata[SW-1:CRD_W];
                cur_r_reg <= s_rdata[CRD_W-1:0];
            end
            S_FPAINT:
            begin
                cnt_reg <= cnt_reg + 1'b1;
                dir_reg <= DIR_LEFT;
            end
            S_NBISS, S_NBCHK:
            begin
                if (!((state_reg == S_NBISS) && u_ok))
                begin
                    case (dir_reg)
                        DIR_LEFT:  dir_reg <= DIR_RIGHT;
                        DIR_RIGHT: dir_reg <= DIR_UP;
                        DIR_UP:    dir_reg <= DIR_DOWN;
                        default:   dir_reg <= DIR_DOWN;
                    endcase
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_reg.cell_value    <= value_reg;
                    out_reg.cells_changed <= cnt_reg;
                    out_reg.status        <= bad_reg;
                end
            end
            default:
            begin
                value_reg <= value_reg;
            end
        endcase
    end

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_FULL)
        else $error("fill stack pointer beyond depth");

    a_stack_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (sp_reg == '0))
        else $error("fill stack not empty between operations");

    a_flag_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status) |-> ((out_data.cells_changed == '0)
                                            && (out_data.cell_value == '0)))
        else $error("flagged result reports painted cells or a value");

endmodule

/* tb/tb_grid_flood_fill_engine_top.sv */
module tb_grid_flood_fill_engine_top;
    import gff_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;
    localparam int CELLS = MAX_COLS * MAX_ROWS;
    localparam int CYCLE_LIMIT = 8000000;
    localparam int LONG_HOLD = 120000;
    localparam int HOLD_AFTER = 66;
    localparam int SETTLE_CYCLES = 8;
    localparam int STEP_DC [4] = '{-1, 1, 0, 0};
    localparam int STEP_DR [4] = '{0, 0, -1, 1};

    typedef enum logic [1:0] {
        JOB_OP,
        JOB_CFG,
        JOB_DRAIN
    } job_kind_t;

    typedef struct {
        job_kind_t  kind;
        in_item_t   item;
        reg_idx_t   idx;
        logic [7:0] val;
    } job_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_ready;
    out_item_t  out_data;
    logic       cfg_we;
    reg_idx_t   cfg_index;
    logic [7:0] cfg_wdata;

    grid_flood_fill_engine_top #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // shadow of the block
    logic [7:0] canvas [CELLS];
    logic       seen [CELLS];
    int         fill_todo [CELLS];
    logic [6:0] sh_cols;
    logic [6:0] sh_rows;
    logic [7:0] sh_paint;
    logic       sh_erase;

    job_t      job_q [$];
    out_item_t awaited_results [$];
    int        errors;
    int        results_seen;
    int        send_gap;
    int        settle;
    int        recv_gap;
    int        recv_hold;
    bit        hold_done;
    bit        no_idle;
    int        cycles;

    function automatic int eff_cols();
        return (sh_cols > MAX_COLS) ? MAX_COLS : int'(sh_cols);
    endfunction

    function automatic int eff_rows();
        return (sh_rows > MAX_ROWS) ? MAX_ROWS : int'(sh_rows);
    endfunction

    function automatic bit on_canvas(int c, int r);
        return c >= 0 && r >= 0 && c < eff_cols() && r < eff_rows();
    endfunction

    function automatic logic [7:0] brush();
        return sh_erase ? SPACE_CHAR : sh_paint;
    endfunction

    function automatic int fill_region(int c0, int r0);
        int cnt;
        int sp;
        int idx;
        int nc;
        int nr;
        int ni;
        logic [7:0] target;
        logic [7:0] pv;
        cnt = 0;
        target = canvas[c0 * MAX_ROWS + r0];
        pv = brush();
        foreach (seen[i]) seen[i] = 1'b0;
        sp = 0;
        seen[c0 * MAX_ROWS + r0] = 1'b1;
        fill_todo[sp] = c0 * MAX_ROWS + r0;
        sp = sp + 1;
        while (sp > 0) begin
            sp = sp - 1;
            idx = fill_todo[sp];
            canvas[idx] = pv;
            cnt++;
            for (int d = 0; d < 4; d++) begin
                nc = idx / MAX_ROWS + STEP_DC[d];
                nr = idx % MAX_ROWS + STEP_DR[d];
                if (on_canvas(nc, nr)) begin
                    ni = nc * MAX_ROWS + nr;
                    if (!seen[ni] && canvas[ni] == target) begin
                        seen[ni] = 1'b1;
                        fill_todo[sp] = ni;
                        sp = sp + 1;
                    end
                end
            end
        end
        return cnt;
    endfunction

    function automatic out_item_t apply_op(in_item_t it);
        out_item_t res;
        int cnt;
        int clo;
        int chi;
        int rlo;
        int rhi;
        res = '0;
        cnt = 0;
        if (!on_canvas(it.col_a, it.row_a) ||
            (it.opcode == OP_RECT && !on_canvas(it.col_b, it.row_b))) begin
            res.status = 1'b1;
        end
        else begin
            case (it.opcode)
                OP_WRITE:
                begin
                    canvas[it.col_a * MAX_ROWS + it.row_a] = brush();
                    cnt = 1;
                end
                OP_RECT:
                begin
                    clo = (it.col_a < it.col_b) ? it.col_a : it.col_b;
                    chi = (it.col_a < it.col_b) ? it.col_b : it.col_a;
                    rlo = (it.row_a < it.row_b) ? it.row_a : it.row_b;
                    rhi = (it.row_a < it.row_b) ? it.row_b : it.row_a;
                    for (int c = clo; c <= chi; c++)
                        for (int r = rlo; r <= rhi; r++)
                        begin
                            canvas[c * MAX_ROWS + r] = brush();
                            cnt++;
                        end
                end
                OP_FLOOD:
                    cnt = fill_region(it.col_a, it.row_a);
                default:
                    res.cell_value = canvas[it.col_a * MAX_ROWS + it.row_a];
            endcase
        end
        res.cells_changed = cnt[CNT_W-1:0];
        return res;
    endfunction

    function automatic void apply_reg(reg_idx_t idx, logic [7:0] val);
        case (idx)
            REG_COLS:  sh_cols = val[6:0];
            REG_ROWS:  sh_rows = val[6:0];
            REG_PAINT: sh_paint = val;
            default:   sh_erase = val[0];
        endcase
    endfunction

    task automatic add_op(op_t op, int ca, int ra, int cb, int rb);
        job_t j;
        j.kind = JOB_OP;
        j.item.opcode = op;
        j.item.col_a = ca[5:0];
        j.item.row_a = ra[5:0];
        j.item.col_b = cb[5:0];
        j.item.row_b = rb[5:0];
        j.idx = REG_COLS;
        j.val = '0;
        job_q.insert(job_q.size(), j);
    endtask

    task automatic add_cfg(reg_idx_t idx, int val);
        job_t j;
        j.kind = JOB_CFG;
        j.item = '0;
        j.idx = idx;
        j.val = val[7:0];
        job_q.insert(job_q.size(), j);
    endtask

    task automatic add_drain();
        job_t j;
        j.kind = JOB_DRAIN;
        j.item = '0;
        j.idx = REG_COLS;
        j.val = '0;
        job_q.insert(job_q.size(), j);
    endtask

    task automatic add_setup(int cols, int rows, int paint, int erase);
        add_cfg(REG_COLS, cols);
        add_cfg(REG_ROWS, rows);
        add_cfg(REG_PAINT, paint);
        add_cfg(REG_ERASE, erase);
    endtask

    function automatic int pick_coord(int lim);
        if ($urandom_range(0, 7) == 0 || lim < 1)
            return $urandom_range(0, 63);
        return $urandom_range(0, lim - 1);
    endfunction

    task automatic add_random(int n, int cols, int rows, int flood_weight);
        int cl;
        int rl;
        int pick;
        op_t op;
        cl = (cols > MAX_COLS) ? MAX_COLS : cols;
        rl = (rows > MAX_ROWS) ? MAX_ROWS : rows;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < flood_weight)
                op = OP_FLOOD;
            else if (pick < 5)
                op = OP_WRITE;
            else if (pick < 7)
                op = OP_RECT;
            else
                op = OP_READ;
            add_op(op, pick_coord(cl), pick_coord(rl), pick_coord(cl), pick_coord(rl));
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            in_data   <= '0;
            cfg_we    <= 1'b0;
            cfg_index <= REG_COLS;
            cfg_wdata <= '0;
            send_gap  <= 0;
            settle    <= 0;
        end
        else begin
            automatic logic nv = in_valid;
            automatic logic nwe = 1'b0;
            automatic job_t j;
            if (in_valid && in_ready) begin
                awaited_results.insert(awaited_results.size(), apply_op(in_data));
                nv = 1'b0;
            end
            if (awaited_results.size() == 0 && !nv)
                settle <= settle + 1;
            else
                settle <= 0;
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end
                else if (job_q.size() > 0) begin
                    j = job_q[0];
                    case (j.kind)
                        JOB_OP:
                        begin
                            in_data <= j.item;
                            nv = 1'b1;
                            void'(job_q.pop_front());
                            send_gap <= no_idle ? 0 : $urandom_range(0, 9);
                        end
                        JOB_CFG:
                        begin
                            if (awaited_results.size() == 0 && settle >= SETTLE_CYCLES) begin
                                nwe = 1'b1;
                                cfg_index <= j.idx;
                                cfg_wdata <= j.val;
                                apply_reg(j.idx, j.val);
                                void'(job_q.pop_front());
                            end
                        end
                        default:
                        begin
                            if (awaited_results.size() == 0)
                                void'(job_q.pop_front());
                        end
                    endcase
                end
            end
            in_valid <= nv;
            cfg_we   <= nwe;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_ready    <= 1'b0;
            recv_gap     <= 0;
            recv_hold    <= 0;
            hold_done    <= 1'b0;
            results_seen <= 0;
        end
        else begin
            automatic out_item_t exp_r;
            automatic int gap = recv_gap;
            automatic int hold = recv_hold;
            if (out_valid && out_ready) begin
                results_seen <= results_seen + 1;
                if (awaited_results.size() == 0) begin
                    $display("%0t: result with nothing awaited: %p", $time, out_data);
                    errors++;
                end
                else begin
                    exp_r = awaited_results.pop_front();
                    if (out_data.cell_value !== exp_r.cell_value) begin
                        $display("%0t: cell_value expected %0d actual %0d", $time,
                                 exp_r.cell_value, out_data.cell_value);
                        errors++;
                    end
                    if (out_data.cells_changed !== exp_r.cells_changed) begin
                        $display("%0t: cells_changed expected %0d actual %0d", $time,
                                 exp_r.cells_changed, out_data.cells_changed);
                        errors++;
                    end
                    if (out_data.status !== exp_r.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 exp_r.status, out_data.status);
                        errors++;
                    end
                end
                gap = no_idle ? 0 : $urandom_range(0, 9);
                if (!hold_done && results_seen >= HOLD_AFTER) begin
                    hold = LONG_HOLD;
                    hold_done <= 1'b1;
                end
            end
            if (hold > 0) begin
                hold--;
                out_ready <= 1'b0;
            end
            else if (gap > 0) begin
                gap--;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= 1'b1;
            end
            recv_gap  <= gap;
            recv_hold <= hold;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_grid_flood_fill_engine_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        cycles = 0;
        no_idle = 1'b0;
        foreach (canvas[i]) canvas[i] = SPACE_CHAR;
        sh_cols = 7'd64;
        sh_rows = 7'd64;
        sh_paint = SPACE_CHAR;
        sh_erase = 1'b0;

        // directed
        add_op(OP_READ, 63, 63, 0, 0);
        add_op(OP_FLOOD, 63, 63, 63, 63);
        add_setup(8, 6, 65, 0);
        add_op(OP_WRITE, 0, 0, 63, 63);
        add_op(OP_WRITE, 7, 5, 0, 0);
        add_op(OP_READ, 0, 0, 0, 0);
        add_op(OP_READ, 7, 5, 63, 63);
        add_op(OP_WRITE, 8, 0, 0, 0);
        add_op(OP_READ, 0, 6, 0, 0);
        add_op(OP_RECT, 5, 4, 2, 1);
        add_op(OP_RECT, 1, 1, 63, 63);
        add_op(OP_RECT, 0, 0, 7, 5);
        add_op(OP_FLOOD, 3, 3, 0, 0);
        add_op(OP_WRITE, 3, 3, 0, 0);
        add_op(OP_READ, 4, 2, 0, 0);
        add_op(OP_FLOOD, 8, 6, 0, 0);
        add_setup(8, 6, 255, 1);
        add_op(OP_FLOOD, 0, 0, 0, 0);
        add_op(OP_RECT, 7, 0, 0, 5);
        add_op(OP_READ, 6, 4, 0, 0);
        add_setup(0, 0, 0, 0);
        add_op(OP_WRITE, 0, 0, 0, 0);
        add_op(OP_READ, 0, 0, 0, 0);
        add_setup(127, 100, 66, 0);
        add_op(OP_RECT, 63, 63, 60, 0);
        add_op(OP_READ, 63, 63, 0, 0);
        add_op(OP_READ, 62, 2, 0, 0);

        // random
        add_setup(5, 7, $urandom_range(0, 255), 0);
        add_random(14, 5, 7, 3);
        add_setup(1, 1, $urandom_range(0, 255), 0);
        add_random(6, 1, 1, 3);
        add_setup(16, 16, $urandom_range(0, 255), 0);
        add_random(10, 16, 16, 3);
        add_drain();
        add_random(10, 16, 16, 3);
        add_setup(64, 64, $urandom_range(0, 255), 0);
        add_random(14, 64, 64, 1);
        add_setup(127, 3, $urandom_range(0, 255), 1);
        add_random(8, 64, 3, 3);
        add_setup(3, 64, $urandom_range(0, 255), 0);
        add_random(12, 3, 64, 3);
        add_setup(10, 12, $urandom_range(0, 255), $urandom_range(0, 1));
        add_random(6, 10, 12, 3);

        while (job_q.size() != 0) @(posedge clk);
        no_idle = 1'b1;
        add_setup(6, 6, $urandom_range(0, 255), 0);
        add_random(10, 6, 6, 3);

        while (job_q.size() != 0) @(posedge clk);
        @(posedge clk);
        while (in_valid || awaited_results.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0 && awaited_results.size() == 0)
            $display("tb_grid_flood_fill_engine_top: PASS");
        else
            $display("tb_grid_flood_fill_engine_top: FAIL");
        $finish;
    end

endmodule

/* grid_flood_fill_engine_top.f */
hdl/gff_pkg.sv
hdl/gff_ram.sv
hdl/gff_step.sv
hdl/grid_flood_fill_engine_top.sv
tb/tb_grid_flood_fill_engine_top.sv
